// ----- sv/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and the Magma round function.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned HALF_W    = 32;
  localparam int unsigned NUM_KEYS  = 8;
  localparam int unsigned KIDX_W    = 3;
  localparam int unsigned NUM_RNDS  = 32;
  localparam int unsigned ROT_LEFT  = 11;
  localparam int unsigned FWD_RNDS  = 24;

  typedef logic [HALF_W-1:0] half_t;

  typedef struct packed {
    half_t hi;
    half_t lo;
  } block_t;

  typedef logic [3:0] nib_t;

  localparam nib_t SBOX [8][16] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // add key, substitute each nibble, rotate left
  function automatic half_t round_f(input half_t x, input half_t rk);
    half_t sum;
    half_t sub;
    sum = x + rk;
    for (int n = 0; n < 8; n++) begin
      sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
    end
    return {sub[HALF_W-1-ROT_LEFT:0], sub[HALF_W-1:HALF_W-ROT_LEFT]};
  endfunction

endpackage

// ----- sv/mbe_round.sv -----
// ----------------------------------------------------------------------------
// mbe_round
// One registered Feistel round with its own valid bit and ready chain.
// ----------------------------------------------------------------------------
module mbe_round
  import mbe_pkg::*;
#(
  parameter bit IS_LAST = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  block_t up_data,
  input  half_t  rkey,
  output logic   dn_valid,
  input  logic   dn_ready,
  output block_t dn_data
);

  logic   valid_r;
  block_t data_r;
  block_t data_nxt;
  half_t  f;

  assign f        = round_f(up_data.lo, rkey);
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    if (IS_LAST) begin
      data_nxt.hi = up_data.hi ^ f;
      data_nxt.lo = up_data.lo;
    end else begin
      data_nxt.hi = up_data.lo;
      data_nxt.lo = up_data.hi ^ f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // advance payload only when a word moves in
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- sv/magma_block_encrypt_top.sv -----
// Throughput: one 64-bit word per cycle while out_ready stays high; each of the 32
// round stages holds a word, one round per stage.
// Stages drain independently, so bubbles close up under an output stall.
// Reset (rst_n low, synchronous): clears all stage valid bits and the key to zero.
// ----------------------------------------------------------------------------
// magma_block_encrypt_top
// GOST 28147-89 / Magma 64-bit block encryption, ECB, fully unrolled pipeline.
// ----------------------------------------------------------------------------
module magma_block_encrypt_top
  import mbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [KIDX_W-1:0]   cfg_index,
  input  logic [HALF_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [HALF_W-1:0]   in_left_in,
  input  logic [HALF_W-1:0]   in_right_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [HALF_W-1:0]   out_left_out,
  output logic [HALF_W-1:0]   out_right_out
);

  half_t  key_r [NUM_KEYS];

  logic   st_valid [NUM_RNDS+1];
  logic   st_ready [NUM_RNDS+1];
  block_t st_data  [NUM_RNDS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_r[k] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign st_valid[0]    = in_valid;
  assign st_data[0].hi  = in_left_in;
  assign st_data[0].lo  = in_right_in;
  assign in_ready       = st_ready[0];
  assign st_ready[NUM_RNDS] = out_ready;

  for (genvar r = 0; r < NUM_RNDS; r++) begin : g_rnd
    // key words 0..7 three times, then reversed
    localparam int unsigned KSEL = (r < FWD_RNDS) ? (r % NUM_KEYS)
                                                  : (NUM_KEYS - 1 - (r % NUM_KEYS));
    mbe_round #(
      .IS_LAST (r == NUM_RNDS - 1)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[r]),
      .up_ready (st_ready[r]),
      .up_data  (st_data[r]),
      .rkey     (key_r[KSEL]),
      .dn_valid (st_valid[r+1]),
      .dn_ready (st_ready[r+1]),
      .dn_data  (st_data[r+1])
    );
  end

  assign out_valid     = st_valid[NUM_RNDS];
  assign out_left_out  = st_data[NUM_RNDS].hi;
  assign out_right_out = st_data[NUM_RNDS].lo;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !st_valid[1])
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> st_valid[1])
    else $error("accepted word missing from first stage");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    st_valid[16] && !st_ready[16] |=> st_valid[16] && $stable(st_data[16]))
    else $error("stalled mid stage lost or changed its word");

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && st_valid[NUM_RNDS-1] |-> !st_ready[NUM_RNDS-1])
    else $error("stage accepted into a full stalled stage");

endmodule

// ----- tb/mbe_cipher_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_cipher_check
// Tracks the key writes, computes the Magma ciphertext of every accepted
// plaintext word and compares it field by field with the words that leave
// the block, in order.
// ----------------------------------------------------------------------------
module mbe_cipher_check
  import mbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [KIDX_W-1:0]  cfg_index,
  input  logic [HALF_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [HALF_W-1:0]  in_left_in,
  input  logic [HALF_W-1:0]  in_right_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [HALF_W-1:0]  out_left_out,
  input  logic [HALF_W-1:0]  out_right_out,
  output int unsigned        errors,
  output int unsigned        blocks_due,
  output int unsigned        blocks_checked
);

  half_t  key_reg [NUM_KEYS];
  block_t cipher_due [$];

  initial begin
    errors         = 0;
    blocks_due     = 0;
    blocks_checked = 0;
    for (int i = 0; i < NUM_KEYS; i++) key_reg[i] = '0;
  end

  function automatic half_t mix_half(input half_t x, input half_t rk);
    half_t s;
    half_t sub;
    s = x + rk;
    for (int n = 0; n < 8; n++) begin
      sub[4*n +: 4] = SBOX[n][s[4*n +: 4]];
    end
    return (sub << ROT_LEFT) | (sub >> (HALF_W - ROT_LEFT));
  endfunction

  function automatic block_t encipher(input half_t hi, input half_t lo);
    half_t  a;
    half_t  b;
    half_t  t;
    half_t  rk;
    block_t res;
    a = hi;
    b = lo;
    for (int r = 0; r < NUM_RNDS - 1; r++) begin
      rk = (r < FWD_RNDS) ? key_reg[r % NUM_KEYS] : key_reg[NUM_RNDS - 1 - r];
      t = a ^ mix_half(b, rk);
      a = b;
      b = t;
    end
    // last round keeps the halves in place
    a = a ^ mix_half(b, key_reg[0]);
    res.hi = a;
    res.lo = b;
    return res;
  endfunction

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) key_reg[i] = '0;
      cipher_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_due.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected output word %08h_%08h", $realtime,
                     out_left_out, out_right_out);
          end
        end else begin
          want = cipher_due.pop_front();
          blocks_checked++;
          if (out_left_out !== want.hi || out_right_out !== want.lo) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch left exp %08h got %08h, right exp %08h got %08h",
                       $realtime, want.hi, out_left_out, want.lo, out_right_out);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        cipher_due.push_back(encipher(in_left_in, in_right_in));
      end
      if (cfg_we) begin
        key_reg[cfg_index] = cfg_wdata;
      end
    end
    blocks_due = cipher_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives plaintext words and key settings into the Magma pipeline with bursty
// input and a stalling output; the checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
  import mbe_pkg::*;

  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 200;
  localparam int unsigned DRAIN_WAIT = 40;

  typedef enum int {RX_FREE, RX_COIN, RX_BEAT, RX_HOLD} rx_mode_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [KIDX_W-1:0]  cfg_index = '0;
  logic [HALF_W-1:0]  cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [HALF_W-1:0]  in_left_in  = '0;
  logic [HALF_W-1:0]  in_right_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [HALF_W-1:0]  out_left_out;
  logic [HALF_W-1:0]  out_right_out;

  int unsigned errors;
  int unsigned blocks_due;
  int unsigned blocks_checked;
  int unsigned cycles    = 0;
  int unsigned burst_left = 0;
  int unsigned key_sets  = 0;
  bit          steady    = 1'b0;

  rx_mode_t    rx_mode   = RX_FREE;
  int unsigned rx_left   = 0;
  int unsigned rx_tick   = 0;

  magma_block_encrypt_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out)
  );

  mbe_cipher_check i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .errors        (errors),
    .blocks_due    (blocks_due),
    .blocks_checked(blocks_checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: switch between free flow, coin flips, a beat and long holds
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_BEAT: out_ready <= (rx_tick % 5) != 0;
      default: out_ready <= (rx_tick % 40) >= 30;
    endcase
  end

  function automatic half_t rand_half();
    half_t v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      2:       v = half_t'(1) << $urandom_range(0, HALF_W - 1);
      3:       v = ~(half_t'(1) << $urandom_range(0, HALF_W - 1));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic push_block(input half_t hi, input half_t lo);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (!steady && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_left_in  <= hi;
    in_right_in <= lo;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and hold until every word in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (blocks_due != 0) @(negedge clk);
  endtask

  task automatic write_keys(input half_t kw [NUM_KEYS]);
    for (int i = 0; i < NUM_KEYS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= KIDX_W'(i);
      cfg_wdata <= kw[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    key_sets++;
  endtask

  initial begin
    half_t kw [NUM_KEYS];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // key left at its reset value
    key_sets = 1;
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'hffff_ffff);
    push_block(32'h0000_0000, 32'hffff_ffff);
    push_block(32'hffff_ffff, 32'h0000_0000);
    push_block(32'haaaa_aaaa, 32'h5555_5555);
    push_block(32'h8000_0000, 32'h0000_0001);
    push_block(32'h0000_0001, 32'h8000_0000);
    drain();

    // published test key and block
    kw = '{32'hffee_ddcc, 32'hbbaa_9988, 32'h7766_5544, 32'h3322_1100,
           32'hf0f1_f2f3, 32'hf4f5_f6f7, 32'hf8f9_fafb, 32'hfcfd_feff};
    write_keys(kw);
    push_block(32'hfedc_ba98, 32'h7654_3210);
    push_block(32'h4ee9_01e5, 32'hc2d8_ca3d);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'hffff_ffff);
    drain();

    // all-ones key: a key addition carries unless the half is zero
    for (int i = 0; i < NUM_KEYS; i++) kw[i] = '1;
    write_keys(kw);
    push_block(32'h0000_0000, 32'h0000_0000);
    push_block(32'hffff_ffff, 32'hffff_ffff);
    push_block(32'h1234_5678, 32'h9abc_def0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < NUM_KEYS; i++) kw[i] = rand_half();
      write_keys(kw);
      steady     = (ph % 3) == 0;
      burst_left = 0;
      for (int j = 0; j < PHASE_LEN; j++) begin
        if (ph == 3 && j == PHASE_LEN / 2) drain();
        push_block(rand_half(), rand_half());
      end
      drain();
    end

    // write the zero key back and run a final short batch
    for (int i = 0; i < NUM_KEYS; i++) kw[i] = '0;
    write_keys(kw);
    steady = 1'b0;
    for (int j = 0; j < 16; j++) push_block(rand_half(), rand_half());
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    $display("covered %0d blocks under %0d key settings (zero, all-ones, test and random keys)",
             blocks_checked, key_sets);
    $display("with bursty input, output stalls up to 30 cycles and %0d mismatches", errors);
    if (errors == 0 && blocks_due == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
